### rtl/core/pl0_pkg.sv
// Package for the PL/0 lexical scanner: token codes, result kinds, error codes
// and the queue entry type shared by the front and back parts. No dependencies.
package pl0_pkg;

  localparam int MaxIdentLen = 11;
  localparam int MaxNumberDigits = 5;
  localparam int WlenW = $clog2(MaxIdentLen + 1);
  localparam int WidxW = (MaxIdentLen > 1) ? $clog2(MaxIdentLen) : 1;
  localparam int DcntW = $clog2(MaxNumberDigits + 1);
  localparam logic [16:0] ValueMax = 17'd131071;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_IDLONG   = 3'd1;
  localparam logic [2:0] ERR_NUMLONG  = 3'd2;
  localparam logic [2:0] ERR_DIGITLED = 3'd3;
  localparam logic [2:0] ERR_INVALID  = 3'd4;

  localparam logic [5:0] TK_NONE    = 6'd0;
  localparam logic [5:0] TK_MOD     = 6'd1;
  localparam logic [5:0] TK_IDENT   = 6'd2;
  localparam logic [5:0] TK_NUMBER  = 6'd3;
  localparam logic [5:0] TK_PLUS    = 6'd4;
  localparam logic [5:0] TK_MINUS   = 6'd5;
  localparam logic [5:0] TK_MULT    = 6'd6;
  localparam logic [5:0] TK_SLASH   = 6'd7;
  localparam logic [5:0] TK_ODD     = 6'd8;
  localparam logic [5:0] TK_EQL     = 6'd9;
  localparam logic [5:0] TK_NEQ     = 6'd10;
  localparam logic [5:0] TK_LES     = 6'd11;
  localparam logic [5:0] TK_LEQ     = 6'd12;
  localparam logic [5:0] TK_GTR     = 6'd13;
  localparam logic [5:0] TK_GEQ     = 6'd14;
  localparam logic [5:0] TK_LPAREN  = 6'd15;
  localparam logic [5:0] TK_RPAREN  = 6'd16;
  localparam logic [5:0] TK_COMMA   = 6'd17;
  localparam logic [5:0] TK_SEMI    = 6'd18;
  localparam logic [5:0] TK_PERIOD  = 6'd19;
  localparam logic [5:0] TK_BECOMES = 6'd20;
  localparam logic [5:0] TK_BEGIN   = 6'd21;
  localparam logic [5:0] TK_END     = 6'd22;
  localparam logic [5:0] TK_IF      = 6'd23;
  localparam logic [5:0] TK_THEN    = 6'd24;
  localparam logic [5:0] TK_WHILE   = 6'd25;
  localparam logic [5:0] TK_DO      = 6'd26;
  localparam logic [5:0] TK_CALL    = 6'd27;
  localparam logic [5:0] TK_CONST   = 6'd28;
  localparam logic [5:0] TK_VAR     = 6'd29;
  localparam logic [5:0] TK_PROC    = 6'd30;
  localparam logic [5:0] TK_WRITE   = 6'd31;
  localparam logic [5:0] TK_READ    = 6'd32;
  localparam logic [5:0] TK_ELSE    = 6'd33;

  // Command from front to back: one simple result, or a word flush
  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_WORD
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  kind;
    logic [5:0]  tok;
    logic [16:0] value;
    logic [2:0]  err;
    logic        last;
  } fq_entry_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

### rtl/core/pl0_lexical_scanner.sv
// PL/0 lexical scanner top level: front scanner and back result sequencer.
// Uses pl0_pkg, pl0_front, pl0_back.
// One character is taken per cycle while the command queue has room; a
// finished word then holds input until its token, and for an identifier one
// result per character (up to 12 results in all), are loaded into the result
// register; a character that ends a token and is itself a symbol pushes a
// second command, and input is held until that command is queued.
module pl0_lexical_scanner import pl0_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_result_kind,
  output logic [5:0]  out_token_type,
  output logic [16:0] out_number_value,
  output logic [7:0]  out_lexeme_char,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  logic             q_full, q_push, busy, wr_en, snap, word_busy;
  fq_entry_t        q_data;
  logic [WidxW-1:0] wr_idx;
  logic [7:0]       wr_char;
  logic [WlenW-1:0] snap_len;

  assign full = busy || q_full;

  pl0_front u_front (
    .clk, .rst_n, .in_valid(push && !full), .char_code(in_char_code),
    .end_of_text(in_end_of_text), .q_full, .busy, .q_push, .q_data,
    .wr_en, .wr_idx, .wr_char, .snap, .snap_len, .word_busy
  );

  pl0_back u_back (
    .clk, .rst_n, .q_push, .q_data, .q_full, .wr_en, .wr_idx, .wr_char,
    .snap, .snap_len, .word_busy, .out_empty(empty), .out_pop(pop),
    .out_result_kind, .out_token_type, .out_number_value, .out_lexeme_char,
    .out_error_code, .out_last_of_run
  );

endmodule

### rtl/core/pl0_front.sv
// Front part of the PL/0 scanner: per-character mode machine, word buffer
// writes, number accumulation; pushes up to two commands. Uses pl0_pkg.
module pl0_front import pl0_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       char_code,
  input  logic             end_of_text,
  input  logic             q_full,
  output logic             busy,
  output logic             q_push,
  output fq_entry_t        q_data,
  output logic             wr_en,
  output logic [WidxW-1:0] wr_idx,
  output logic [7:0]       wr_char,
  output logic             snap,
  output logic [WlenW-1:0] snap_len,
  input  logic             word_busy
);

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_NUMBER, M_BADNUM, M_COLON,
    M_LESS, M_GREATER, M_SLASH, M_COMMENT, M_COMSTAR
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [WlenW-1:0] wlen_r, wlen_nxt;
  logic             wlong_r, wlong_nxt;
  logic [16:0]      acc_r, acc_nxt;
  logic [DcntW-1:0] dcnt_r, dcnt_nxt;
  logic             nlong_r, nlong_nxt;
  // second pending command
  logic             pend_r, pend_nxt;
  fq_entry_t        pend_q_r, pend_q_nxt;

  fq_entry_t        e0, e1;
  logic             v0, v1;
  logic [7:0]       c;
  logic             is_l, is_d, idle_scan, wr_now;
  logic [20:0]      mul10;
  logic [16:0]      dval;

  assign busy = pend_r || word_busy;
  assign c = char_code;
  assign is_l = is_letter(c);
  assign is_d = is_digit(c);
  assign mul10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {13'd0, c - 8'h30};
  assign dval = (mul10 > {4'd0, ValueMax}) ? ValueMax : mul10[16:0];

  function automatic fq_entry_t mk(input logic [1:0] k, input logic [5:0] t,
                                   input logic [16:0] v, input logic [2:0] e);
    fq_entry_t r;
    r.cmd = CMD_EMIT; r.kind = k; r.tok = t; r.value = v; r.err = e; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_nxt = mode_r; wlen_nxt = wlen_r; wlong_nxt = wlong_r;
    acc_nxt = acc_r; dcnt_nxt = dcnt_r; nlong_nxt = nlong_r;
    pend_nxt = pend_r; pend_q_nxt = pend_q_r;
    e0 = mk(KIND_TOKEN, TK_NONE, 17'd0, ERR_NONE); e1 = e0;
    v0 = 1'b0; v1 = 1'b0; idle_scan = 1'b0; wr_now = 1'b0;
    snap = 1'b0;
    q_push = 1'b0; q_data = e0;
    if (pend_r) begin
      if (!q_full && !word_busy) begin
        q_push = 1'b1; q_data = pend_r ? pend_q_r : e0; pend_nxt = 1'b0;
      end
    end else if (in_valid) begin
      if (end_of_text) begin
        case (mode_r)
          M_WORD: begin
            v0 = 1'b1;
            if (wlong_r) e0 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_IDLONG);
            else begin e0.cmd = CMD_WORD; snap = 1'b1; end
          end
          M_NUMBER: begin
            v0 = 1'b1;
            e0 = nlong_r ? mk(KIND_ERROR, TK_NONE, 17'd0, ERR_NUMLONG)
                         : mk(KIND_TOKEN, TK_NUMBER, acc_r, ERR_NONE);
          end
          M_COLON: begin v0 = 1'b1; e0 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_INVALID); end
          M_LESS: begin v0 = 1'b1; e0 = mk(KIND_TOKEN, TK_LES, 17'd0, ERR_NONE); end
          M_GREATER: begin v0 = 1'b1; e0 = mk(KIND_TOKEN, TK_GTR, 17'd0, ERR_NONE); end
          M_SLASH: begin v0 = 1'b1; e0 = mk(KIND_TOKEN, TK_SLASH, 17'd0, ERR_NONE); end
          default: ;
        endcase
        mode_nxt = M_IDLE; wlen_nxt = '0; wlong_nxt = 1'b0;
        acc_nxt = '0; dcnt_nxt = '0; nlong_nxt = 1'b0;
      end else begin
        case (mode_r)
          M_WORD: begin
            if (is_l || is_d) begin
              if (wlen_r < WlenW'(MaxIdentLen)) begin
                wr_now = 1'b1; wlen_nxt = wlen_r + 1'b1;
              end else wlong_nxt = 1'b1;
            end else begin
              v0 = 1'b1;
              if (wlong_r) e0 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_IDLONG);
              else begin e0.cmd = CMD_WORD; snap = 1'b1; end
              wlen_nxt = '0; wlong_nxt = 1'b0; idle_scan = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_d) begin
              if (dcnt_r < DcntW'(MaxNumberDigits)) begin
                acc_nxt = dval; dcnt_nxt = dcnt_r + 1'b1;
              end else nlong_nxt = 1'b1;
            end else if (is_l) begin
              v0 = 1'b1; e0 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_DIGITLED);
              acc_nxt = '0; dcnt_nxt = '0; nlong_nxt = 1'b0; mode_nxt = M_BADNUM;
            end else begin
              v0 = 1'b1;
              e0 = nlong_r ? mk(KIND_ERROR, TK_NONE, 17'd0, ERR_NUMLONG)
                           : mk(KIND_TOKEN, TK_NUMBER, acc_r, ERR_NONE);
              acc_nxt = '0; dcnt_nxt = '0; nlong_nxt = 1'b0; idle_scan = 1'b1;
            end
          end
          M_BADNUM: if (!(is_l || is_d)) idle_scan = 1'b1;
          M_COLON: begin
            v0 = 1'b1;
            if (c == 8'h3d) begin
              e0 = mk(KIND_TOKEN, TK_BECOMES, 17'd0, ERR_NONE); mode_nxt = M_IDLE;
            end else begin
              e0 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_INVALID); idle_scan = 1'b1;
            end
          end
          M_LESS: begin
            v0 = 1'b1; mode_nxt = M_IDLE;
            if (c == 8'h3e) e0 = mk(KIND_TOKEN, TK_NEQ, 17'd0, ERR_NONE);
            else if (c == 8'h3d) e0 = mk(KIND_TOKEN, TK_LEQ, 17'd0, ERR_NONE);
            else begin e0 = mk(KIND_TOKEN, TK_LES, 17'd0, ERR_NONE); idle_scan = 1'b1; end
          end
          M_GREATER: begin
            v0 = 1'b1; mode_nxt = M_IDLE;
            if (c == 8'h3d) e0 = mk(KIND_TOKEN, TK_GEQ, 17'd0, ERR_NONE);
            else begin e0 = mk(KIND_TOKEN, TK_GTR, 17'd0, ERR_NONE); idle_scan = 1'b1; end
          end
          M_SLASH: begin
            if (c == 8'h2a) mode_nxt = M_COMMENT;
            else begin
              v0 = 1'b1; e0 = mk(KIND_TOKEN, TK_SLASH, 17'd0, ERR_NONE); idle_scan = 1'b1;
            end
          end
          M_COMMENT: if (c == 8'h2a) mode_nxt = M_COMSTAR;
          M_COMSTAR: begin
            if (c == 8'h2f) mode_nxt = M_IDLE;
            else if (c != 8'h2a) mode_nxt = M_COMMENT;
          end
          default: idle_scan = 1'b1;
        endcase
        if (idle_scan) begin
          mode_nxt = M_IDLE;
          if (is_l) begin
            mode_nxt = M_WORD; wlen_nxt = WlenW'(1); wlong_nxt = 1'b0; wr_now = 1'b1;
          end else if (is_d) begin
            mode_nxt = M_NUMBER; acc_nxt = {9'd0, c - 8'h30};
            dcnt_nxt = DcntW'(1); nlong_nxt = 1'b0;
          end else if (c <= 8'd32 || c == 8'd127) begin
          end else begin
            case (c)
              8'h3a: mode_nxt = M_COLON;
              8'h3c: mode_nxt = M_LESS;
              8'h3e: mode_nxt = M_GREATER;
              8'h2f: mode_nxt = M_SLASH;
              default: begin
                v1 = 1'b1;
                case (c)
                  8'h25: e1 = mk(KIND_TOKEN, TK_MOD, 17'd0, ERR_NONE);
                  8'h2b: e1 = mk(KIND_TOKEN, TK_PLUS, 17'd0, ERR_NONE);
                  8'h2d: e1 = mk(KIND_TOKEN, TK_MINUS, 17'd0, ERR_NONE);
                  8'h2a: e1 = mk(KIND_TOKEN, TK_MULT, 17'd0, ERR_NONE);
                  8'h3d: e1 = mk(KIND_TOKEN, TK_EQL, 17'd0, ERR_NONE);
                  8'h28: e1 = mk(KIND_TOKEN, TK_LPAREN, 17'd0, ERR_NONE);
                  8'h29: e1 = mk(KIND_TOKEN, TK_RPAREN, 17'd0, ERR_NONE);
                  8'h2c: e1 = mk(KIND_TOKEN, TK_COMMA, 17'd0, ERR_NONE);
                  8'h3b: e1 = mk(KIND_TOKEN, TK_SEMI, 17'd0, ERR_NONE);
                  8'h2e: e1 = mk(KIND_TOKEN, TK_PERIOD, 17'd0, ERR_NONE);
                  default: e1 = mk(KIND_ERROR, TK_NONE, 17'd0, ERR_INVALID);
                endcase
              end
            endcase
          end
        end
      end
      if (v1) e1.last = 1'b1;
      else e0.last = 1'b1;
      if (v0) begin
        q_push = 1'b1; q_data = e0;
        if (v1) begin pend_nxt = 1'b1; pend_q_nxt = e1; end
      end else if (v1) begin
        q_push = 1'b1; q_data = e1;
      end
    end
  end

  assign wr_en = wr_now;
  assign wr_idx = wr_now && (mode_r == M_WORD) && !idle_scan ? wlen_r[WidxW-1:0] : '0;
  assign wr_char = c;
  assign snap_len = wlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; wlen_r <= '0; wlong_r <= 1'b0;
      acc_r <= '0; dcnt_r <= '0; nlong_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; wlen_r <= wlen_nxt; wlong_r <= wlong_nxt;
      acc_r <= acc_nxt; dcnt_r <= dcnt_nxt; nlong_r <= nlong_nxt; pend_r <= pend_nxt;
    end
    pend_q_r <= pend_q_nxt;
  end

endmodule

### rtl/core/pl0_back.sv
// Back part of the PL/0 scanner: command queue, word snapshot, keyword match
// and the result sequencer with its output register. Uses pl0_pkg.
module pl0_back import pl0_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_push,
  input  fq_entry_t        q_data,
  output logic             q_full,
  input  logic             wr_en,
  input  logic [WidxW-1:0] wr_idx,
  input  logic [7:0]       wr_char,
  input  logic             snap,
  input  logic [WlenW-1:0] snap_len,
  output logic             word_busy,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_result_kind,
  output logic [5:0]       out_token_type,
  output logic [16:0]      out_number_value,
  output logic [7:0]       out_lexeme_char,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);

  localparam int QD = 4;

  fq_entry_t        q_r [QD];
  logic [1:0]       wp_r, rp_r;
  logic [2:0]       cnt_r;
  logic [7:0]       buf_r [MaxIdentLen];
  logic [7:0]       snap_r [MaxIdentLen];
  logic [WlenW-1:0] slen_r;
  logic             wpend_r;  // snapshot held, not yet consumed
  logic             run_r;    // emitting identifier characters
  logic [WlenW-1:0] ci_r;
  logic             runlast_r;
  logic             ov_r;
  logic [1:0]       ok_r;
  logic [5:0]       ot_r;
  logic [16:0]      onv_r;
  logic [7:0]       oc_r;
  logic [2:0]       oe_r;
  logic             ol_r;

  fq_entry_t  head;
  logic       slot_free, q_pop;
  logic [5:0] kw;
  logic [7:0] w [9];

  assign q_full = (cnt_r >= 3'd3);
  assign word_busy = wpend_r;
  assign head = q_r[rp_r];
  assign slot_free = !ov_r || out_pop;

  always_comb begin
    for (int i = 0; i < 9; i++) w[i] = (i < MaxIdentLen) ? snap_r[i] : 8'h00;
    kw = TK_NONE;
    case (slen_r)
      WlenW'(2): begin
        if (w[0] == "d" && w[1] == "o") kw = TK_DO;
        if (w[0] == "i" && w[1] == "f") kw = TK_IF;
      end
      WlenW'(3): begin
        if ({w[0], w[1], w[2]} == "end") kw = TK_END;
        if ({w[0], w[1], w[2]} == "odd") kw = TK_ODD;
        if ({w[0], w[1], w[2]} == "var") kw = TK_VAR;
      end
      WlenW'(4): begin
        if ({w[0], w[1], w[2], w[3]} == "call") kw = TK_CALL;
        if ({w[0], w[1], w[2], w[3]} == "else") kw = TK_ELSE;
        if ({w[0], w[1], w[2], w[3]} == "read") kw = TK_READ;
        if ({w[0], w[1], w[2], w[3]} == "then") kw = TK_THEN;
      end
      WlenW'(5): begin
        if ({w[0], w[1], w[2], w[3], w[4]} == "begin") kw = TK_BEGIN;
        if ({w[0], w[1], w[2], w[3], w[4]} == "const") kw = TK_CONST;
        if ({w[0], w[1], w[2], w[3], w[4]} == "while") kw = TK_WHILE;
        if ({w[0], w[1], w[2], w[3], w[4]} == "write") kw = TK_WRITE;
      end
      WlenW'(9): if ({w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]} == "procedure")
        kw = TK_PROC;
      default: ;
    endcase
  end

  assign q_pop = slot_free && !run_r && (cnt_r != 3'd0);

  always_ff @(posedge clk) begin
    if (wr_en) buf_r[wr_idx] <= wr_char;
    if (snap) begin
      for (int i = 0; i < MaxIdentLen; i++) snap_r[i] <= buf_r[i];
      slen_r <= snap_len;
    end
    if (q_push) q_r[wp_r] <= q_data;
    if (slot_free) begin
      if (run_r) begin
        ok_r <= KIND_CHAR; ot_r <= TK_NONE; onv_r <= '0; oe_r <= ERR_NONE;
        oc_r <= snap_r[ci_r[WidxW-1:0]];
        ol_r <= runlast_r && (ci_r == slen_r - 1'b1);
      end else if (q_pop) begin
        oc_r <= 8'h00;
        if (head.cmd == CMD_WORD) begin
          ok_r <= KIND_TOKEN; onv_r <= '0; oe_r <= ERR_NONE;
          ot_r <= (kw != TK_NONE) ? kw : TK_IDENT;
          ol_r <= (kw != TK_NONE) ? head.last : 1'b0;
        end else begin
          ok_r <= head.kind; ot_r <= head.tok; onv_r <= head.value;
          oe_r <= head.err; ol_r <= head.last;
        end
      end
    end
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; wpend_r <= 1'b0;
      run_r <= 1'b0; ci_r <= '0; runlast_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (q_push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'b0, q_push} - {2'b0, q_pop};
      if (snap) wpend_r <= 1'b1;
      if (slot_free) begin
        ov_r <= run_r || q_pop;
        if (run_r) begin
          ci_r <= ci_r + 1'b1;
          if (ci_r == slen_r - 1'b1) begin run_r <= 1'b0; wpend_r <= 1'b0; end
        end else if (q_pop && head.cmd == CMD_WORD) begin
          if (kw != TK_NONE) wpend_r <= 1'b0;
          else begin run_r <= 1'b1; ci_r <= '0; runlast_r <= head.last; end
        end
      end
    end
  end

  assign out_empty = !ov_r;
  assign out_result_kind = ok_r;
  assign out_token_type = ot_r;
  assign out_number_value = onv_r;
  assign out_lexeme_char = oc_r;
  assign out_error_code = oe_r;
  assign out_last_of_run = ol_r;

endmodule

### rtl/core/pl0_checker.sv
// Port-level checker for the PL/0 scanner, bound to the top level.
// Uses pl0_pkg.
module pl0_checker import pl0_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_result_kind,
  input logic [5:0]  out_token_type,
  input logic [2:0]  out_error_code,
  input logic [7:0]  out_lexeme_char
);

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_result_kind == KIND_TOKEN || out_result_kind == KIND_CHAR ||
                out_result_kind == KIND_ERROR))
    else $error("bad result kind");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind != KIND_ERROR) |-> out_error_code == ERR_NONE)
    else $error("error code on non-error");
  a_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind != KIND_TOKEN) |-> out_token_type == TK_NONE)
    else $error("token type on non-token");
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind != KIND_CHAR) |-> out_lexeme_char == 8'h00)
    else $error("lexeme character on non-character result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_token_type)))
    else $error("result dropped");

endmodule

bind pl0_lexical_scanner pl0_checker u_checker (
  .clk, .rst_n, .empty, .pop, .out_result_kind, .out_token_type,
  .out_error_code, .out_lexeme_char
);
